@@ design/stet_pkg.sv @@
// ----------------------------------------------------------------------------
// stet_pkg
// Shared constants and types for the sorted top-entries table.
// ----------------------------------------------------------------------------
package stet_pkg;

    localparam int SLOTS_DEFAULT      = 9;
    localparam int SCORE_BITS_DEFAULT = 8;

    localparam int LETTER_W = 8;
    localparam int SLOT_W   = 4;
    localparam int MARGIN_W = 9;

    localparam logic [LETTER_W-1:0] DASH_CHAR = 8'h2D;

    localparam logic OP_INSERT = 1'b0;
    localparam logic OP_READ   = 1'b1;

    typedef struct packed {
        logic [LETTER_W-1:0] first;
        logic [LETTER_W-1:0] second;
        logic [LETTER_W-1:0] third;
    } letters_t;

    // control passed down the row of cells
    typedef struct packed {
        logic insert;   // an insert word is being taken this cycle
        logic found;    // some earlier cell already qualified
    } cell_ctrl_t;

endpackage

@@ design/stet_cell.sv @@
// ----------------------------------------------------------------------------
// stet_cell
// One table slot: holds an entry, decides whether it takes the new entry,
// takes its upper neighbour's entry or keeps its own, and drives read data.
// ----------------------------------------------------------------------------
module stet_cell
    import stet_pkg::*;
#(
    parameter int SCORE_BITS = SCORE_BITS_DEFAULT,
    parameter int INDEX      = 0,
    parameter int CMP_W      = 8
)
(
    input  logic                         clk,
    input  logic                         rst_n,
    input  cell_ctrl_t                   ctrl_in,
    output cell_ctrl_t                   ctrl_out,
    input  letters_t                     new_letters,
    input  logic [SCORE_BITS-1:0]        new_own,
    input  logic [SCORE_BITS-1:0]        new_rival,
    input  logic signed [SCORE_BITS:0]   new_margin,
    input  letters_t                     prev_letters,
    input  logic [SCORE_BITS-1:0]        prev_own,
    input  logic [SCORE_BITS-1:0]        prev_rival,
    input  logic signed [SCORE_BITS:0]   prev_margin,
    output letters_t                     letters,
    output logic [SCORE_BITS-1:0]        own,
    output logic [SCORE_BITS-1:0]        rival,
    output logic signed [SCORE_BITS:0]   margin,
    output logic                         take,
    input  logic [CMP_W-1:0]             read_index,
    output letters_t                     rd_letters,
    output logic [SCORE_BITS-1:0]        rd_own,
    output logic [SCORE_BITS-1:0]        rd_rival,
    output logic signed [SCORE_BITS:0]   rd_margin
);

    letters_t                   letters_reg, letters_next;
    logic [SCORE_BITS-1:0]      own_reg, own_next;
    logic [SCORE_BITS-1:0]      rival_reg, rival_next;
    logic signed [SCORE_BITS:0] margin_reg, margin_next;
    logic                       qualify;
    logic                       hit;

    // zero-zero counts as empty
    assign qualify = (new_margin >= margin_reg) || ((own_reg == '0) && (rival_reg == '0));
    assign take    = ctrl_in.insert && !ctrl_in.found && qualify;

    assign ctrl_out.insert = ctrl_in.insert;
    assign ctrl_out.found  = ctrl_in.found || qualify;

    always_comb
    begin
        letters_next = letters_reg;
        own_next     = own_reg;
        rival_next   = rival_reg;
        margin_next  = margin_reg;
        if (ctrl_in.insert && ctrl_in.found)
        begin
            letters_next = prev_letters;
            own_next     = prev_own;
            rival_next   = prev_rival;
            margin_next  = prev_margin;
        end
        else if (take)
        begin
            letters_next = new_letters;
            own_next     = new_own;
            rival_next   = new_rival;
            margin_next  = new_margin;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            letters_reg <= '{first: DASH_CHAR, second: DASH_CHAR, third: DASH_CHAR};
            own_reg     <= '0;
            rival_reg   <= '0;
            margin_reg  <= '0;
        end
        else
        begin
            letters_reg <= letters_next;
            own_reg     <= own_next;
            rival_reg   <= rival_next;
            margin_reg  <= margin_next;
        end
    end

    assign letters = letters_reg;
    assign own     = own_reg;
    assign rival   = rival_reg;
    assign margin  = margin_reg;

    assign hit = (read_index == CMP_W'(INDEX));

    assign rd_letters = hit ? letters_reg : '0;
    assign rd_own     = hit ? own_reg     : '0;
    assign rd_rival   = hit ? rival_reg   : '0;
    assign rd_margin  = hit ? margin_reg  : '0;

endmodule

@@ design/sorted_top_entries_table.sv @@
// ----------------------------------------------------------------------------
// sorted_top_entries_table
// Table of SLOTS entries kept sorted by margin, largest first.
// ----------------------------------------------------------------------------
// Input channel (in_valid / in_stall): op selects insert or read. An insert
// places the entry at the first slot whose margin is less than or equal to
// the new margin, or whose scores are both zero; later slots move down one
// and the last drops off. A read returns the slot named by read_slot.
// Output channel (out_valid / out_stall): one result word per input word.
// Insert results carry placed_slot (SLOTS when not placed), other fields zero.
// The result is registered on the edge that takes the word. Throughput is one
// word per cycle while in_stall is low; every cell compares in parallel and
// the first-match flag ripples down the row of cells within the same cycle.
// When the receiver stalls with a result held, in_stall rises and the table
// is left as it is. Reset clears out_valid but not the result fields; every
// slot then holds '-' letters and zero scores.
// ----------------------------------------------------------------------------
module sorted_top_entries_table
    import stet_pkg::*;
#(
    parameter int SLOTS      = SLOTS_DEFAULT,
    parameter int SCORE_BITS = SCORE_BITS_DEFAULT
)
(
    input  logic                       clk,
    input  logic                       rst_n,
    input  logic                       in_valid,
    output logic                       in_stall,
    input  logic                       op,
    input  logic [LETTER_W-1:0]        first_letter,
    input  logic [LETTER_W-1:0]        second_letter,
    input  logic [LETTER_W-1:0]        third_letter,
    input  logic [7:0]                 own_score,
    input  logic [7:0]                 rival_score,
    input  logic [SLOT_W-1:0]          read_slot,
    output logic                       out_valid,
    input  logic                       out_stall,
    output logic [SLOT_W-1:0]          placed_slot,
    output logic [LETTER_W-1:0]        out_first_letter,
    output logic [LETTER_W-1:0]        out_second_letter,
    output logic [LETTER_W-1:0]        out_third_letter,
    output logic [7:0]                 out_own_score,
    output logic [7:0]                 out_rival_score,
    output logic signed [MARGIN_W-1:0] out_margin
);

    localparam int IDX_W = $clog2(SLOTS + 1);
    localparam int CMP_W = (IDX_W > SLOT_W) ? IDX_W : SLOT_W;

    logic                       accept;
    logic                       valid_reg;
    cell_ctrl_t                 ctrl [SLOTS+1];
    letters_t                   new_letters;
    logic [SCORE_BITS-1:0]      new_own, new_rival;
    logic signed [SCORE_BITS:0] new_margin;
    logic [CMP_W-1:0]           read_index;

    letters_t                   c_letters [SLOTS];
    logic [SCORE_BITS-1:0]      c_own     [SLOTS];
    logic [SCORE_BITS-1:0]      c_rival   [SLOTS];
    logic signed [SCORE_BITS:0] c_margin  [SLOTS];
    logic [SLOTS-1:0]           c_take;
    letters_t                   r_letters [SLOTS];
    logic [SCORE_BITS-1:0]      r_own     [SLOTS];
    logic [SCORE_BITS-1:0]      r_rival   [SLOTS];
    logic signed [SCORE_BITS:0] r_margin  [SLOTS];

    letters_t                   sel_letters;
    logic [SCORE_BITS-1:0]      sel_own, sel_rival;
    logic signed [SCORE_BITS:0] sel_margin;
    logic [IDX_W-1:0]           pos;

    logic [SLOT_W-1:0]          slot_reg, slot_next;
    letters_t                   letters_reg, letters_next;
    logic [7:0]                 own_reg, own_next;
    logic [7:0]                 rival_reg, rival_next;
    logic signed [MARGIN_W-1:0] margin_reg, margin_next;

    assign in_stall = valid_reg && out_stall;
    assign accept   = in_valid && !in_stall;

    assign new_letters = '{first: first_letter, second: second_letter, third: third_letter};
    assign new_own     = SCORE_BITS'(own_score);
    assign new_rival   = SCORE_BITS'(rival_score);
    assign new_margin  = $signed({1'b0, new_own}) - $signed({1'b0, new_rival});
    assign read_index  = CMP_W'(read_slot);

    assign ctrl[0].insert = accept && (op == OP_INSERT);
    assign ctrl[0].found  = 1'b0;

    for (genvar j = 0; j < SLOTS; j++)
    begin : g_cell
        letters_t                   p_letters;
        logic [SCORE_BITS-1:0]      p_own, p_rival;
        logic signed [SCORE_BITS:0] p_margin;

        if (j == 0)
        begin : g_head
            // head cell never shifts; neighbour inputs are don't-care
            assign p_letters = new_letters;
            assign p_own     = new_own;
            assign p_rival   = new_rival;
            assign p_margin  = new_margin;
        end
        else
        begin : g_body
            assign p_letters = c_letters[j-1];
            assign p_own     = c_own[j-1];
            assign p_rival   = c_rival[j-1];
            assign p_margin  = c_margin[j-1];
        end

        stet_cell #(
            .SCORE_BITS (SCORE_BITS),
            .INDEX      (j),
            .CMP_W      (CMP_W)
        ) u_cell (
            .clk          (clk),
            .rst_n        (rst_n),
            .ctrl_in      (ctrl[j]),
            .ctrl_out     (ctrl[j+1]),
            .new_letters  (new_letters),
            .new_own      (new_own),
            .new_rival    (new_rival),
            .new_margin   (new_margin),
            .prev_letters (p_letters),
            .prev_own     (p_own),
            .prev_rival   (p_rival),
            .prev_margin  (p_margin),
            .letters      (c_letters[j]),
            .own          (c_own[j]),
            .rival        (c_rival[j]),
            .margin       (c_margin[j]),
            .take         (c_take[j]),
            .read_index   (read_index),
            .rd_letters   (r_letters[j]),
            .rd_own       (r_own[j]),
            .rd_rival     (r_rival[j]),
            .rd_margin    (r_margin[j])
        );
    end

    // at most one cell hits or takes, so OR-combining selects it
    always_comb
    begin
        sel_letters = '0;
        sel_own     = '0;
        sel_rival   = '0;
        sel_margin  = '0;
        pos         = ctrl[SLOTS].found ? '0 : IDX_W'(SLOTS);
        for (int j = 0; j < SLOTS; j++)
        begin
            sel_letters = sel_letters | r_letters[j];
            sel_own     = sel_own | r_own[j];
            sel_rival   = sel_rival | r_rival[j];
            sel_margin  = sel_margin | r_margin[j];
            if (c_take[j])
            begin
                pos = pos | IDX_W'(j);
            end
        end
    end

    always_comb
    begin
        slot_next    = slot_reg;
        letters_next = letters_reg;
        own_next     = own_reg;
        rival_next   = rival_reg;
        margin_next  = margin_reg;
        if (accept)
        begin
            if (op == OP_INSERT)
            begin
                slot_next    = SLOT_W'(pos);
                letters_next = '0;
                own_next     = '0;
                rival_next   = '0;
                margin_next  = '0;
            end
            else
            begin
                slot_next    = read_slot;
                letters_next = sel_letters;
                own_next     = 8'(sel_own);
                rival_next   = 8'(sel_rival);
                margin_next  = MARGIN_W'(sel_margin);
            end
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            valid_reg <= 1'b0;
        end
        else if (accept)
        begin
            valid_reg <= 1'b1;
        end
        else if (!out_stall)
        begin
            valid_reg <= 1'b0;
        end
    end

    always_ff @(posedge clk)
    begin
        slot_reg    <= slot_next;
        letters_reg <= letters_next;
        own_reg     <= own_next;
        rival_reg   <= rival_next;
        margin_reg  <= margin_next;
    end

    assign out_valid         = valid_reg;
    assign placed_slot       = slot_reg;
    assign out_first_letter  = letters_reg.first;
    assign out_second_letter = letters_reg.second;
    assign out_third_letter  = letters_reg.third;
    assign out_own_score     = own_reg;
    assign out_rival_score   = rival_reg;
    assign out_margin        = margin_reg;

endmodule

@@ test/stet_checker.sv @@
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// stet_checker
// Watches both channels of the sorted top-entries table, keeps a shadow copy
// of the table, predicts each result word and compares it field by field.
// ----------------------------------------------------------------------------
module stet_checker
    import stet_pkg::*;
#(
    parameter int SLOTS = SLOTS_DEFAULT
)
(
    input  logic                       clk,
    input  logic                       rst_n,
    input  logic                       in_valid,
    input  logic                       in_stall,
    input  logic                       op,
    input  logic [LETTER_W-1:0]        first_letter,
    input  logic [LETTER_W-1:0]        second_letter,
    input  logic [LETTER_W-1:0]        third_letter,
    input  logic [7:0]                 own_score,
    input  logic [7:0]                 rival_score,
    input  logic [SLOT_W-1:0]          read_slot,
    input  logic                       out_valid,
    input  logic                       out_stall,
    input  logic [SLOT_W-1:0]          placed_slot,
    input  logic [LETTER_W-1:0]        out_first_letter,
    input  logic [LETTER_W-1:0]        out_second_letter,
    input  logic [LETTER_W-1:0]        out_third_letter,
    input  logic [7:0]                 out_own_score,
    input  logic [7:0]                 out_rival_score,
    input  logic signed [MARGIN_W-1:0] out_margin,
    output int                         fail_count,
    output int                         outstanding,
    output int                         placed_count,
    output int                         refused_count
);

    typedef struct packed {
        logic [SLOT_W-1:0]          slot;
        letters_t                   letters;
        logic [7:0]                 own;
        logic [7:0]                 rival;
        logic signed [MARGIN_W-1:0] margin;
    } table_reply_t;

    letters_t                   shadow_letters [SLOTS];
    logic [7:0]                 shadow_own     [SLOTS];
    logic [7:0]                 shadow_rival   [SLOTS];
    logic signed [MARGIN_W-1:0] shadow_margin  [SLOTS];

    table_reply_t awaited_replies [$];

    // Applies one word to the shadow table and returns the reply it should give.
    function automatic table_reply_t apply_word(
        input logic              w_op,
        input letters_t          w_letters,
        input logic [7:0]        w_own,
        input logic [7:0]        w_rival,
        input logic [SLOT_W-1:0] w_slot
    );
        table_reply_t               r;
        logic signed [MARGIN_W-1:0] m;
        int                         pos;
        int                         j;
        r = '0;
        if (w_op == OP_INSERT)
        begin
            m   = $signed({1'b0, w_own}) - $signed({1'b0, w_rival});
            pos = SLOTS;
            // first slot with a margin no better than the new one, or an empty one
            for (j = 0; j < SLOTS && pos == SLOTS; j++)
            begin
                if (m >= shadow_margin[j] || (shadow_own[j] == 8'd0 && shadow_rival[j] == 8'd0))
                    pos = j;
            end
            if (pos < SLOTS)
            begin
                for (j = SLOTS - 1; j > pos; j--)
                begin
                    shadow_letters[j] = shadow_letters[j-1];
                    shadow_own[j]     = shadow_own[j-1];
                    shadow_rival[j]   = shadow_rival[j-1];
                    shadow_margin[j]  = shadow_margin[j-1];
                end
                shadow_letters[pos] = w_letters;
                shadow_own[pos]     = w_own;
                shadow_rival[pos]   = w_rival;
                shadow_margin[pos]  = m;
            end
            r.slot = SLOT_W'(pos);
        end
        else
        begin
            r.slot = w_slot;
            if (w_slot < SLOTS)
            begin
                r.letters = shadow_letters[w_slot];
                r.own     = shadow_own[w_slot];
                r.rival   = shadow_rival[w_slot];
                r.margin  = shadow_margin[w_slot];
            end
        end
        return r;
    endfunction

    always @(posedge clk or negedge rst_n)
    begin
        table_reply_t got;
        table_reply_t want;
        if (!rst_n)
        begin
            for (int s = 0; s < SLOTS; s++)
            begin
                shadow_letters[s] = '{DASH_CHAR, DASH_CHAR, DASH_CHAR};
                shadow_own[s]     = '0;
                shadow_rival[s]   = '0;
                shadow_margin[s]  = '0;
            end
            awaited_replies.delete();
            fail_count    = 0;
            placed_count  = 0;
            refused_count = 0;
            outstanding   = 0;
        end
        else
        begin
            if (out_valid && !out_stall)
            begin
                got = {placed_slot, out_first_letter, out_second_letter, out_third_letter,
                       out_own_score, out_rival_score, out_margin};
                if (awaited_replies.size() == 0)
                begin
                    fail_count++;
                    if (fail_count <= 10)
                        $display("%0t: result word with nothing awaited: slot %0d", $realtime,
                                 got.slot);
                end
                else
                begin
                    want = awaited_replies.pop_front();
                    if (got.slot !== want.slot || got.letters !== want.letters ||
                        got.own !== want.own || got.rival !== want.rival ||
                        got.margin !== want.margin)
                    begin
                        fail_count++;
                        if (fail_count <= 10)
                        begin
                            $display("%0t: mismatch", $realtime);
                            $display("  want slot %0d letters %h own %0d rival %0d margin %0d",
                                     want.slot, want.letters, want.own, want.rival,
                                     want.margin);
                            $display("  got  slot %0d letters %h own %0d rival %0d margin %0d",
                                     got.slot, got.letters, got.own, got.rival,
                                     got.margin);
                        end
                    end
                end
            end
            if (in_valid && !in_stall)
            begin
                want = apply_word(op, '{first_letter, second_letter, third_letter},
                                  own_score, rival_score, read_slot);
                if (op == OP_INSERT)
                begin
                    if (want.slot == SLOT_W'(SLOTS))
                        refused_count++;
                    else
                        placed_count++;
                end
                awaited_replies.push_back(want);
            end
            outstanding = awaited_replies.size();
        end
    end

endmodule

@@ test/sorted_top_entries_table_test.sv @@
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// sorted_top_entries_table_test
// Drives inserts and reads into the sorted top-entries table with random gaps
// and output stalls; a checker beside the block predicts every result word.
// ----------------------------------------------------------------------------
module sorted_top_entries_table_test;
    import stet_pkg::*;

    localparam int CYCLE_LIMIT  = 200000;
    localparam int RANDOM_WORDS = 900;

    logic                       clk;
    logic                       rst_n;
    logic                       in_valid;
    logic                       in_stall;
    logic                       op;
    logic [LETTER_W-1:0]        first_letter;
    logic [LETTER_W-1:0]        second_letter;
    logic [LETTER_W-1:0]        third_letter;
    logic [7:0]                 own_score;
    logic [7:0]                 rival_score;
    logic [SLOT_W-1:0]          read_slot;
    logic                       out_valid;
    logic                       out_stall;
    logic [SLOT_W-1:0]          placed_slot;
    logic [LETTER_W-1:0]        out_first_letter;
    logic [LETTER_W-1:0]        out_second_letter;
    logic [LETTER_W-1:0]        out_third_letter;
    logic [7:0]                 out_own_score;
    logic [7:0]                 out_rival_score;
    logic signed [MARGIN_W-1:0] out_margin;

    int fail_count;
    int outstanding;
    int placed_count;
    int refused_count;

    int  cycle_count;
    int  read_count;
    int  far_read_count;
    bit  steady;
    bit  in_stall_seen;

    sorted_top_entries_table dut (.*);

    stet_checker checker_i (.*);

    initial
    begin
        clk = 1'b0;
        forever #5 clk = ~clk;
    end

    // in_stall settles after the edge; sample it mid-cycle
    always @(negedge clk)
        in_stall_seen <= in_stall;

    always @(posedge clk)
        out_stall <= !steady && ($urandom_range(99) < 18);

    always @(posedge clk)
    begin
        cycle_count++;
        if (cycle_count > CYCLE_LIMIT)
        begin
            $display("timed out after %0d cycles", cycle_count);
            $display("status: fail");
            $finish;
        end
    end

    function automatic letters_t any_letters();
        return letters_t'(24'($urandom));
    endfunction

    task automatic send_word(
        input logic              w_op,
        input letters_t          w_letters,
        input logic [7:0]        w_own,
        input logic [7:0]        w_rival,
        input logic [SLOT_W-1:0] w_slot
    );
        while (!steady && $urandom_range(99) < 18)
        begin
            in_valid <= 1'b0;
            @(posedge clk);
        end
        in_valid      <= 1'b1;
        op            <= w_op;
        first_letter  <= w_letters.first;
        second_letter <= w_letters.second;
        third_letter  <= w_letters.third;
        own_score     <= w_own;
        rival_score   <= w_rival;
        read_slot     <= w_slot;
        @(posedge clk);
        while (in_stall_seen)
            @(posedge clk);
        if (w_op == OP_READ)
        begin
            read_count++;
            if (w_slot >= SLOTS_DEFAULT)
                far_read_count++;
        end
    endtask

    initial
    begin
        int          pick;
        logic [7:0]  a;
        logic [7:0]  b;
        logic [3:0]  s;
        rst_n         <= 1'b0;
        in_valid      <= 1'b0;
        op            <= OP_INSERT;
        first_letter  <= '0;
        second_letter <= '0;
        third_letter  <= '0;
        own_score     <= '0;
        rival_score   <= '0;
        read_slot     <= '0;
        steady        = 1'b0;
        repeat (9) @(posedge clk);
        rst_n <= 1'b1;
        @(posedge clk);

        // table straight out of reset, both ends and beyond the end
        send_word(OP_READ, any_letters(), 8'd0, 8'd0, 4'd0);
        send_word(OP_READ, any_letters(), 8'd0, 8'd0, 4'd8);
        send_word(OP_READ, any_letters(), 8'd255, 8'd255, 4'd9);
        send_word(OP_READ, any_letters(), 8'd0, 8'd0, 4'd15);
        // zero-zero entry, then one that must be placed ahead of it as empty
        send_word(OP_INSERT, '{8'h00, 8'h00, 8'h00}, 8'd0, 8'd0, 4'd15);
        send_word(OP_INSERT, '{8'hFF, 8'hFF, 8'hFF}, 8'd0, 8'd255, 4'd0);
        send_word(OP_INSERT, any_letters(), 8'd255, 8'd0, 4'd5);
        send_word(OP_READ, any_letters(), 8'd0, 8'd0, 4'd1);
        send_word(OP_READ, any_letters(), 8'd0, 8'd0, 4'd2);
        // fill with equal margins so later weak entries are turned away
        for (int k = 0; k < 8; k++)
            send_word(OP_INSERT, any_letters(), 8'd128, 8'd0, 4'($urandom));
        send_word(OP_INSERT, any_letters(), 8'd0, 8'd255, 4'd3);
        send_word(OP_INSERT, any_letters(), 8'd10, 8'd10, 4'd7);
        send_word(OP_INSERT, any_letters(), 8'd255, 8'd0, 4'd12);
        send_word(OP_READ, any_letters(), 8'd0, 8'd0, 4'd0);
        send_word(OP_READ, any_letters(), 8'd0, 8'd0, 4'd8);

        for (int i = 0; i < RANDOM_WORDS; i++)
        begin
            steady = (i >= 400 && i < 560);
            if ($urandom_range(99) < 45)
            begin
                s = ($urandom_range(99) < 12) ? 4'($urandom_range(15, 9))
                                               : 4'($urandom_range(8, 0));
                send_word(OP_READ, any_letters(), 8'($urandom), 8'($urandom), s);
            end
            else
            begin
                pick = $urandom_range(9);
                case (pick)
                    0: begin a = 8'd0;   b = 8'd0;   end
                    1: begin a = 8'd255; b = 8'd0;   end
                    2: begin a = 8'd0;   b = 8'd255; end
                    3, 4:
                    begin
                        a = 8'($urandom_range(255, 160));
                        b = 8'($urandom_range(60));
                    end
                    5: begin a = 8'($urandom); b = a; end
                    default: begin a = 8'($urandom); b = 8'($urandom); end
                endcase
                send_word(OP_INSERT, any_letters(), a, b, 4'($urandom));
            end
        end
        steady = 1'b0;
        in_valid <= 1'b0;

        @(negedge clk);
        while (outstanding != 0)
            @(negedge clk);
        repeat (4) @(posedge clk);

        $display("inserts: %0d placed, %0d turned away; reads: %0d, %0d past the last slot",
                 placed_count, refused_count, read_count, far_read_count);
        if (fail_count == 0)
            $display("status: pass");
        else
            $display("status: fail");
        $finish;
    end

endmodule
